// ===== src/tsb_pkg.sv =====
// Shared types and constants of the tile sprite blitter.
package tsb_pkg;

    // Sheet store geometry: 256 x 256 entries of 2-bit palette indices.
    localparam int SHEET_AW    = 16;
    localparam int SHEET_DEPTH = 1 << SHEET_AW;
    localparam int SHEET_DW    = 2;

    // Tiles are 8 x 8, 32 tiles to a sheet row.
    localparam int TILE_AW   = 3;
    localparam int TILE_COLW = 5;
    localparam int TILE_NUMW = 10;
    localparam int PIX_CNTW  = 2 * TILE_AW;
    localparam logic [PIX_CNTW-1:0] PIX_LAST = '1;

    // Screen and coordinate widths.
    localparam int DIMW  = 11;
    localparam int POSW  = 16;
    localparam int WPOSW = POSW + 1;
    localparam int ADDRW = 20;
    localparam int COLW  = 8;
    localparam int PALW  = 32;

    localparam logic [DIMW-1:0] MAX_SCREEN_DIM = 11'd1024;
    localparam logic [COLW-1:0] TRANSPARENT    = 8'd255;

    localparam logic [DIMW-1:0] RST_SCREEN_W  = 11'd160;
    localparam logic [DIMW-1:0] RST_SCREEN_H  = 11'd120;

    // Configuration register indexes.
    localparam int CFG_IDXW = 2;
    localparam int CFG_DW   = 16;
    localparam logic [CFG_IDXW-1:0] CFG_SCREEN_W = 2'd0;
    localparam logic [CFG_IDXW-1:0] CFG_SCREEN_H = 2'd1;
    localparam logic [CFG_IDXW-1:0] CFG_SCROLL_X = 2'd2;
    localparam logic [CFG_IDXW-1:0] CFG_SCROLL_Y = 2'd3;

    // Item kinds carried in tuser.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    localparam int IN_TDATAW  = 96;
    localparam int OUT_TDATAW = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_EVAL,
        S_FLUSH
    } t_state;

    // Result of the per-pixel clip and address unit.
    typedef struct packed {
        logic             vis;
        logic [ADDRW-1:0] addr;
    } t_pix_res;

endpackage

// ===== src/tsb_pix_unit.sv =====
// Per-pixel clip and framebuffer address unit, reused for every tile pixel.
module tsb_pix_unit (
    input  logic signed [tsb_pkg::WPOSW-1:0] i_xp,
    input  logic signed [tsb_pkg::WPOSW-1:0] i_yp,
    input  logic [tsb_pkg::TILE_AW-1:0]      i_px,
    input  logic [tsb_pkg::TILE_AW-1:0]      i_py,
    input  logic [tsb_pkg::DIMW-1:0]         i_w,
    input  logic [tsb_pkg::DIMW-1:0]         i_h,
    input  logic [tsb_pkg::ADDRW-1:0]        i_row_base,
    output tsb_pkg::t_pix_res                o_res
);
    import tsb_pkg::*;

    logic [WPOSW:0] sx;
    logic [WPOSW:0] sy;
    logic           vis_x;
    logic           vis_y;

    // Screen coordinates, one bit wider than the scrolled position.
    assign sx = {i_xp[WPOSW-1], i_xp} + {{(WPOSW+1-TILE_AW){1'b0}}, i_px};
    assign sy = {i_yp[WPOSW-1], i_yp} + {{(WPOSW+1-TILE_AW){1'b0}}, i_py};

    assign vis_x = !sx[WPOSW] && (sx[WPOSW-1:0] < {{(WPOSW-DIMW){1'b0}}, i_w});
    assign vis_y = !sy[WPOSW] && (sy[WPOSW-1:0] < {{(WPOSW-DIMW){1'b0}}, i_h});

    assign o_res.vis  = vis_x && vis_y;
    assign o_res.addr = {{(ADDRW-WPOSW-1){1'b0}}, sx} + i_row_base;

endmodule

// ===== src/tile_sprite_blitter_top.sv =====
// Top level of the tile sprite blitter: sequencer, sheet store and stream ports.
// Load beat: written to the sheet store on the edge that accepts it.
// Draw beat: a setup step, then per tile pixel a sheet read and an evaluate step,
// then a flush step; output stalls can hold the evaluate and flush steps.
// A pixel write is held until the next hit or the flush.
// s_axis_tready is low while a tile is drawn.
// Synchronous active-low reset clears control state and config registers; the sheet
// store holds no reset value.
module tile_sprite_blitter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [tsb_pkg::CFG_IDXW-1:0]      i_cfg_idx,
    input  logic [tsb_pkg::CFG_DW-1:0]        i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // sheet_address[15:0], sheet_value[17:16], pos_x[33:18], pos_y[49:34],
    // tile_number[59:50], palette[91:60], flip_x[92], flip_y[93], zero[95:94]
    input  logic [tsb_pkg::IN_TDATAW-1:0]     s_axis_tdata,
    // kind[0]
    input  logic                              s_axis_tuser,
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pixel_address[19:0], pixel_color[27:20], zero[31:28]
    output logic [tsb_pkg::OUT_TDATAW-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast
);
    import tsb_pkg::*;

    // input beat fields
    logic [SHEET_AW-1:0]   in_sheet_addr;
    logic [SHEET_DW-1:0]   in_sheet_val;
    logic signed [POSW-1:0] in_pos_x;
    logic signed [POSW-1:0] in_pos_y;
    logic [TILE_NUMW-1:0]  in_tile;
    logic [PALW-1:0]       in_pal;
    logic                  in_flip_x;
    logic                  in_flip_y;

    assign in_sheet_addr = s_axis_tdata[15:0];
    assign in_sheet_val  = s_axis_tdata[17:16];
    assign in_pos_x      = s_axis_tdata[33:18];
    assign in_pos_y      = s_axis_tdata[49:34];
    assign in_tile       = s_axis_tdata[59:50];
    assign in_pal        = s_axis_tdata[91:60];
    assign in_flip_x     = s_axis_tdata[92];
    assign in_flip_y     = s_axis_tdata[93];

    // configuration registers
    logic [DIMW-1:0]        r_cfg_w;
    logic [DIMW-1:0]        r_cfg_h;
    logic signed [POSW-1:0] r_scroll_x;
    logic signed [POSW-1:0] r_scroll_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= RST_SCREEN_W;
            r_cfg_h    <= RST_SCREEN_H;
            r_scroll_x <= '0;
            r_scroll_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCREEN_W: r_cfg_w    <= i_cfg_data[DIMW-1:0];
                CFG_SCREEN_H: r_cfg_h    <= i_cfg_data[DIMW-1:0];
                CFG_SCROLL_X: r_scroll_x <= i_cfg_data;
                CFG_SCROLL_Y: r_scroll_y <= i_cfg_data;
            endcase
        end
    end

    // sequencer state and control
    t_state r_state;
    t_state n_state;

    logic accept;
    logic mem_we;
    logic mem_re;
    logic draw_start;
    logic row_init;
    logic step;
    logic pend_load;
    logic push;
    logic push_last;
    logic out_free;
    logic emit;
    logic stall;

    // draw item registers
    logic signed [WPOSW-1:0] r_xp;
    logic signed [WPOSW-1:0] r_yp;
    logic [TILE_NUMW-1:0]    r_tile;
    logic [PALW-1:0]         r_pal;
    logic                    r_flip_x;
    logic                    r_flip_y;
    logic [DIMW-1:0]         r_w;
    logic [DIMW-1:0]         r_h;
    logic [ADDRW-1:0]        r_row_base;
    logic [PIX_CNTW-1:0]     r_pix;

    logic [TILE_AW-1:0]      px;
    logic [TILE_AW-1:0]      py;
    logic [TILE_AW-1:0]      xs;
    logic [TILE_AW-1:0]      ys;
    logic [SHEET_AW-1:0]     rd_addr;
    logic signed [WPOSW+DIMW:0] row_prod;
    logic [COLW-1:0]         color;
    t_pix_res                pix_res;

    // pending result and output register
    logic                    r_pend_vld;
    logic [ADDRW-1:0]        r_pend_addr;
    logic [COLW-1:0]         r_pend_col;
    logic                    r_out_vld;
    logic [ADDRW-1:0]        r_out_addr;
    logic [COLW-1:0]         r_out_col;
    logic                    r_out_last;

    // sheet store
    logic [SHEET_DW-1:0]     r_sheet [SHEET_DEPTH];
    logic [SHEET_DW-1:0]     r_rd_data;

    assign px = r_pix[TILE_AW-1:0];
    assign py = r_pix[PIX_CNTW-1:TILE_AW];
    assign xs = r_flip_x ? ~px : px;
    assign ys = r_flip_y ? ~py : py;

    // Tile column sits in bits 7:3 and tile row in bits 15:11 of the sheet
    // address; pixel offsets fill the gaps, so no carries arise.
    assign rd_addr = {r_tile[TILE_NUMW-1:TILE_COLW], ys, r_tile[TILE_COLW-1:0], xs};

    // Row base of the first tile row, modulo the framebuffer address range.
    assign row_prod = $signed({{(DIMW+1){r_yp[WPOSW-1]}}, r_yp})
                    * $signed({{(WPOSW+1){1'b0}}, r_w});

    always_comb begin
        case (r_rd_data)
            2'd0:    color = r_pal[7:0];
            2'd1:    color = r_pal[15:8];
            2'd2:    color = r_pal[23:16];
            default: color = r_pal[31:24];
        endcase
    end

    tsb_pix_unit u_pix (
        .i_xp       (r_xp),
        .i_yp       (r_yp),
        .i_px       (px),
        .i_py       (py),
        .i_w        (r_w),
        .i_h        (r_h),
        .i_row_base (r_row_base),
        .o_res      (pix_res)
    );

    assign out_free = !r_out_vld || m_axis_tready;
    assign emit     = pix_res.vis && (color != TRANSPARENT);
    // A second hit needs the pending one moved out first.
    assign stall    = emit && r_pend_vld && !out_free;

    // sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        accept        = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        draw_start    = 1'b0;
        row_init      = 1'b0;
        step          = 1'b0;
        pend_load     = 1'b0;
        push          = 1'b0;
        push_last     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                accept        = s_axis_tvalid;
                mem_we        = accept && (s_axis_tuser == KIND_LOAD);
                draw_start    = accept && (s_axis_tuser == KIND_DRAW);
            end
            S_SETUP: begin
                row_init = 1'b1;
            end
            S_READ: begin
                mem_re = 1'b1;
            end
            S_EVAL: begin
                if (!stall) begin
                    step      = 1'b1;
                    pend_load = emit;
                    push      = emit && r_pend_vld;
                end
            end
            S_FLUSH: begin
                push      = r_pend_vld && out_free;
                push_last = 1'b1;
            end
            default: ;
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (draw_start) n_state = S_SETUP;
            S_SETUP: n_state = S_READ;
            S_READ:  n_state = S_EVAL;
            S_EVAL: begin
                if (step) n_state = (r_pix == PIX_LAST) ? S_FLUSH : S_READ;
            end
            S_FLUSH: if (!r_pend_vld || out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            // hold the newest hit until the next one or the end of the tile
            if (pend_load) begin
                r_pend_vld <= 1'b1;
            end else if (push) begin
                r_pend_vld <= 1'b0;
            end
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // draw payload and walk counters
    always_ff @(posedge i_clk) begin
        if (draw_start) begin
            r_xp     <= {in_pos_x[POSW-1], in_pos_x} - {r_scroll_x[POSW-1], r_scroll_x};
            r_yp     <= {in_pos_y[POSW-1], in_pos_y} - {r_scroll_y[POSW-1], r_scroll_y};
            r_tile   <= in_tile;
            r_pal    <= in_pal;
            r_flip_x <= in_flip_x;
            r_flip_y <= in_flip_y;
            r_w      <= (r_cfg_w > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : r_cfg_w;
            r_h      <= (r_cfg_h > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : r_cfg_h;
        end
        if (row_init) begin
            r_row_base <= row_prod[ADDRW-1:0];
            r_pix      <= '0;
        end else if (step) begin
            r_pix <= r_pix + 1'b1;
            // advance the row base at the end of each tile row
            if (px == PIX_LAST[TILE_AW-1:0]) begin
                r_row_base <= r_row_base + {{(ADDRW-DIMW){1'b0}}, r_w};
            end
        end
        if (pend_load) begin
            r_pend_addr <= pix_res.addr;
            r_pend_col  <= color;
        end
        if (push) begin
            r_out_addr <= r_pend_addr;
            r_out_col  <= r_pend_col;
            r_out_last <= push_last;
        end
    end

    // sheet store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_sheet[in_sheet_addr] <= in_sheet_val;
        end
        if (mem_re) begin
            r_rd_data <= r_sheet[rd_addr];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_TDATAW-ADDRW-COLW){1'b0}}, r_out_col, r_out_addr};
    assign m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    // no result of the previous tile may still be held when a beat is taken
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_pend_vld)
        else $error("pending result left when ready");

    // the walk starts at the first tile pixel
    a_setup_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SETUP |=> (r_state == S_READ) && (r_pix == '0))
        else $error("tile walk did not start at pixel zero");

    // a stalled evaluation keeps the same pixel
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) && stall |=> (r_state == S_EVAL) && $stable(r_pix))
        else $error("pixel lost during output stall");

    // the walk never returns to idle without the flush step
    a_eval_no_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EVAL |=> r_state != S_IDLE)
        else $error("tile walk skipped the flush");
`endif

endmodule

// ===== tb/sv/blit_check_pkg.sv =====
`timescale 1ns / 100ps
// Item types and the framebuffer write scoreboard for the tile sprite blitter testbench.
package blit_check_pkg;
    import tsb_pkg::*;

    localparam int TILE_DIM      = 1 << TILE_AW;
    localparam int TILES_PER_ROW = 1 << TILE_COLW;
    localparam int SHEET_W       = 1 << (TILE_AW + TILE_COLW);
    localparam int TILE_PIXELS   = TILE_DIM * TILE_DIM;

    typedef struct packed {
        logic                  kind;
        logic [SHEET_AW-1:0]   sheet_address;
        logic [SHEET_DW-1:0]   sheet_value;
        logic [POSW-1:0]       pos_x;
        logic [POSW-1:0]       pos_y;
        logic [TILE_NUMW-1:0]  tile_number;
        logic [PALW-1:0]       palette;
        logic                  flip_x;
        logic                  flip_y;
    } t_blit_item;

    typedef struct packed {
        logic [ADDRW-1:0] addr;
        logic [COLW-1:0]  color;
        logic             last;
    } t_fb_write;

    class blit_scoreboard;
        int screen_w;
        int screen_h;
        int scroll_x;
        int scroll_y;
        logic [SHEET_DW-1:0] sheet [SHEET_DEPTH];
        t_fb_write pending_writes[$];
        int mismatches;

        function new();
            screen_w   = RST_SCREEN_W;
            screen_h   = RST_SCREEN_H;
            scroll_x   = 0;
            scroll_y   = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDXW-1:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                CFG_SCREEN_W: screen_w = data[DIMW-1:0];
                CFG_SCREEN_H: screen_h = data[DIMW-1:0];
                CFG_SCROLL_X: scroll_x = $signed(data);
                CFG_SCROLL_Y: scroll_y = $signed(data);
                default: ;
            endcase
        endfunction

        // Walk the tile row-major and queue every visible, opaque pixel.
        function void predict_tile_writes(t_blit_item it);
            int xp, yp, w, h, toffs, sx, sy, xs, ys, n;
            logic [SHEET_AW-1:0] sa;
            logic [SHEET_DW-1:0] pidx;
            logic [COLW-1:0] col;
            t_fb_write wr, prev;
            xp = $signed(it.pos_x) - scroll_x;
            yp = $signed(it.pos_y) - scroll_y;
            w = (screen_w > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : screen_w;
            h = (screen_h > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : screen_h;
            toffs = (it.tile_number % TILES_PER_ROW) * TILE_DIM
                  + (it.tile_number / TILES_PER_ROW) * TILE_DIM * SHEET_W;
            n = 0;
            prev = '0;
            for (int y = 0; y < TILE_DIM; y++) begin
                sy = yp + y;
                if (sy < 0 || sy >= h) continue;
                ys = it.flip_y ? TILE_DIM - 1 - y : y;
                for (int x = 0; x < TILE_DIM; x++) begin
                    sx = xp + x;
                    if (sx < 0 || sx >= w) continue;
                    xs = it.flip_x ? TILE_DIM - 1 - x : x;
                    sa = SHEET_AW'(xs + ys * SHEET_W + toffs);
                    pidx = sheet[sa];
                    col = it.palette[pidx * COLW +: COLW];
                    if (col == TRANSPARENT) continue;
                    wr.addr  = ADDRW'(sx + sy * w);
                    wr.color = col;
                    wr.last  = 1'b0;
                    // hold one write back so the final one can carry last
                    if (n > 0) pending_writes.push_back(prev);
                    prev = wr;
                    n++;
                end
            end
            if (n > 0) begin
                prev.last = 1'b1;
                pending_writes.push_back(prev);
            end
        endfunction

        function void note_item(t_blit_item it);
            if (it.kind == KIND_LOAD) begin
                sheet[it.sheet_address] = it.sheet_value;
            end else begin
                predict_tile_writes(it);
            end
        endfunction

        function void check_write(logic [OUT_TDATAW-1:0] tdata, logic tlast);
            t_fb_write want;
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected write: address %h color %h last %b",
                         $time, tdata[ADDRW-1:0], tdata[ADDRW +: COLW], tlast);
                mismatches++;
                return;
            end
            want = pending_writes.pop_front();
            if (tdata[ADDRW-1:0] !== want.addr) begin
                $display("%0t: pixel_address expected %h got %h",
                         $time, want.addr, tdata[ADDRW-1:0]);
                mismatches++;
            end
            if (tdata[ADDRW +: COLW] !== want.color) begin
                $display("%0t: pixel_color expected %h got %h",
                         $time, want.color, tdata[ADDRW +: COLW]);
                mismatches++;
            end
            if (tlast !== want.last) begin
                $display("%0t: last expected %b got %b", $time, want.last, tlast);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction
    endclass

endpackage

// ===== tb/sv/tile_sprite_blitter_top_tb.sv =====
`timescale 1ns / 100ps
// Top of the tile sprite blitter testbench: clock, reset, stream drivers and run control.
module tile_sprite_blitter_top_tb;
    import tsb_pkg::*;
    import blit_check_pkg::*;

    localparam int ITEM_TARGET  = 450;
    // slowest run: every beat waits the longest gap, every draw walks a whole tile and
    // all 64 writes take the longest stall; several times that stays below this
    localparam int CYCLE_LIMIT  = 1_000_000;
    // longer than one full tile walk, so a draw with no writes has finished
    localparam int DRAIN_CYCLES = 200;
    localparam int NUM_PHASES   = 6;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDXW-1:0]    i_cfg_idx     = '0;
    logic [CFG_DW-1:0]      i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // sheet_address, sheet_value, pos_x, pos_y, tile_number, palette, flip_x, flip_y
    logic [IN_TDATAW-1:0]   s_axis_tdata  = '0;
    // kind
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // pixel_address, pixel_color
    logic [OUT_TDATAW-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;

    tile_sprite_blitter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    blit_scoreboard sb;

    int unsigned cycles = 0;
    int items_sent      = 0;
    int writes_seen     = 0;
    bit send_burst      = 1'b0;
    bit recv_burst      = 1'b0;

    // tiles whose 64 sheet entries are all written; only these get drawn
    int tile_pool[$];
    bit tile_loaded [1024];

    // screen and scroll as the stimulus sees them, to aim draws at the screen
    int gen_w  = RST_SCREEN_W;
    int gen_h  = RST_SCREEN_H;
    int gen_sx = 0;
    int gen_sy = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: give up once the run has gone far past any sane length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tile_sprite_blitter_top_tb: FAIL");
            $finish;
        end
    end

    function automatic t_blit_item make_load(logic [SHEET_AW-1:0] addr,
                                             logic [SHEET_DW-1:0] val);
        t_blit_item it;
        logic [127:0] noise;
        // fill the fields a load ignores with noise
        noise = {$urandom, $urandom, $urandom, $urandom};
        it = noise[$bits(t_blit_item)-1:0];
        it.kind          = KIND_LOAD;
        it.sheet_address = addr;
        it.sheet_value   = val;
        return it;
    endfunction

    function automatic t_blit_item make_draw(logic [POSW-1:0] px, logic [POSW-1:0] py,
                                             logic [TILE_NUMW-1:0] tile,
                                             logic [PALW-1:0] pal, logic fx, logic fy);
        t_blit_item it;
        logic [127:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        it = noise[$bits(t_blit_item)-1:0];
        it.kind        = KIND_DRAW;
        it.pos_x       = px;
        it.pos_y       = py;
        it.tile_number = tile;
        it.palette     = pal;
        it.flip_x      = fx;
        it.flip_y      = fy;
        return it;
    endfunction

    // Entered and left right after a rising edge. Hold valid across a zero
    // gap so back-to-back beats never see valid dropped and raised in one step.
    task automatic send_beat(input t_blit_item it);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {2'b00, it.flip_y, it.flip_x, it.palette, it.tile_number,
                          it.pos_y, it.pos_x, it.sheet_value, it.sheet_address};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_item(it);
        items_sent++;
        // switch between idling and gapless stretches now and then
        if (items_sent % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
    endtask

    // Load the first count entries of a tile, in shuffled order with random
    // indexes. A full load puts the tile in the drawable pool.
    task automatic load_tile(input int t, input int count);
        int offs [TILE_PIXELS];
        int base, k, j, tmp;
        base = (t % TILES_PER_ROW) * TILE_DIM + (t / TILES_PER_ROW) * TILE_DIM * SHEET_W;
        for (k = 0; k < TILE_PIXELS; k++) offs[k] = (k % TILE_DIM) + (k / TILE_DIM) * SHEET_W;
        for (k = TILE_PIXELS - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = offs[k];
            offs[k] = offs[j];
            offs[j] = tmp;
        end
        for (k = 0; k < count; k++) begin
            send_beat(make_load(SHEET_AW'(base + offs[k]),
                                SHEET_DW'($urandom_range(0, 3))));
        end
        if (count == TILE_PIXELS && !tile_loaded[t]) begin
            tile_loaded[t] = 1'b1;
            tile_pool.push_back(t);
        end
    endtask

    // Drop valid, wait for every expected write, then let the block finish
    // any draw that produced nothing.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive edges; only while idle.
    task automatic apply_setting(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h,
                                 input logic [CFG_DW-1:0] sx, input logic [CFG_DW-1:0] sy);
        logic [CFG_DW-1:0] vals [4];
        logic [CFG_IDXW-1:0] idxs [4];
        settle();
        vals = '{w, h, sx, sy};
        idxs = '{CFG_SCREEN_W, CFG_SCREEN_H, CFG_SCROLL_X, CFG_SCROLL_Y};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            sb.set_reg(idxs[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
        gen_w  = (w[DIMW-1:0] > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : w[DIMW-1:0];
        gen_h  = (h[DIMW-1:0] > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : h[DIMW-1:0];
        gen_sx = $signed(sx);
        gen_sy = $signed(sy);
    endtask

    // Output side: draw a stall per write, then hold ready until a beat lands.
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = recv_burst ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            sb.check_write(m_axis_tdata, m_axis_tlast);
            writes_seen++;
            if (writes_seen % 32 == 0) recv_burst = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        int phase_end, pick, t, sx, sy;
        logic [POSW-1:0] px, py;
        logic [PALW-1:0] pal;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the two corner tiles of the sheet first: every directed draw below reads them.
        load_tile(0, TILE_PIXELS);
        load_tile(1023, TILE_PIXELS);

        // Directed: sheet extremes, then draws at the default 160 x 120 screen.
        send_beat(make_load(16'h0000, 2'd3));
        send_beat(make_load(16'hFFFF, 2'd0));
        send_beat(make_load(16'h5A5A, 2'd2));
        // whole tile at and next to the origin, plain and with each mirror
        send_beat(make_draw(16'd0, 16'd0, 10'd0, 32'h0302_0100, 1'b0, 1'b0));
        send_beat(make_draw(16'd8, 16'd0, 10'd0, 32'h0302_0100, 1'b1, 1'b0));
        send_beat(make_draw(16'd0, 16'd8, 10'd0, 32'h0302_0100, 1'b0, 1'b1));
        // bottom-right corner, both mirrors, highest opaque color
        send_beat(make_draw(16'd152, 16'd112, 10'd1023, 32'hFE80_4001, 1'b1, 1'b1));
        // all colors transparent: nothing comes out, no last marker
        send_beat(make_draw(16'd40, 16'd40, 10'd1023, 32'hFFFF_FFFF, 1'b0, 1'b0));
        // two of four colors transparent
        send_beat(make_draw(16'd48, 16'd20, 10'd0, 32'h00FF_FFFE, 1'b0, 1'b0));
        // clip at the left edge, then a tile entirely left of the screen
        send_beat(make_draw(16'hFFFD, 16'd50, 10'd0, 32'h1020_3040, 1'b0, 1'b0));
        send_beat(make_draw(16'hFFF8, 16'd50, 10'd0, 32'h1020_3040, 1'b0, 1'b0));
        // one column and three rows left at the bottom-right edge
        send_beat(make_draw(16'd159, 16'd117, 10'd1023, 32'h1122_3344, 1'b0, 1'b1));
        // just right of the screen, and all but the bottom tile row above the top
        send_beat(make_draw(16'd160, 16'd0, 10'd0, 32'h5566_7788, 1'b0, 1'b0));
        send_beat(make_draw(16'd20, 16'hFFF9, 10'd0, 32'h99AA_BBCC, 1'b1, 1'b0));
        // position extremes, far off screen
        send_beat(make_draw(16'h7FFF, 16'h8000, 10'd1023, $urandom, 1'b1, 1'b0));
        send_beat(make_draw(16'h8000, 16'h7FFF, 10'd0, $urandom, 1'b0, 1'b1));

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: apply_setting(16'd1024, 16'd1024, 16'h8000, 16'h8000);
                1: apply_setting(16'd1, 16'd1, 16'h0000, 16'h0000);
                // widths above the cap saturate; maximum scroll leaves only
                // tiles at or hanging off the left edge reachable
                2: apply_setting(16'hFFFF, 16'h07FF, 16'h7FFF, 16'h0000);
                // zero-sized screen clips everything
                3: apply_setting(16'd0, 16'd0, 16'h0010, 16'h7FFF);
                4: apply_setting(CFG_DW'($urandom_range(1, 300)),
                                 CFG_DW'($urandom_range(1, 300)),
                                 CFG_DW'($urandom_range(0, 65535)),
                                 CFG_DW'($urandom_range(0, 65535)));
                default: apply_setting(16'd160, 16'd120, CFG_DW'($urandom_range(0, 65535)),
                                       CFG_DW'($urandom_range(0, 65535)));
            endcase
            phase_end = items_sent + ((ph == 3) ? 20
                                      : (ITEM_TARGET - items_sent) / (NUM_PHASES - ph));
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 6 && tile_pool.size() < 6) begin
                    do t = $urandom_range(0, 1023); while (tile_loaded[t]);
                    load_tile(t, TILE_PIXELS);
                end else if (pick < 12) begin
                    // stray load anywhere in the sheet
                    send_beat(make_load(SHEET_AW'($urandom_range(0, 65535)),
                                        SHEET_DW'($urandom_range(0, 3))));
                end else if (pick < 15) begin
                    // broken sequence: a tile loaded part way and never drawn
                    do t = $urandom_range(0, 1023); while (tile_loaded[t]);
                    load_tile(t, $urandom_range(1, 20));
                end else begin
                    t = tile_pool[$urandom_range(0, tile_pool.size() - 1)];
                    if ($urandom_range(0, 4) == 0) begin
                        px = POSW'($urandom);
                        py = POSW'($urandom);
                    end else begin
                        // aim near the visible area, in world coordinates
                        sx = $urandom_range(0, gen_w + 16);
                        sy = $urandom_range(0, gen_h + 16);
                        px = POSW'(sx - 8 + gen_sx);
                        py = POSW'(sy - 8 + gen_sy);
                    end
                    pal = $urandom;
                    if ($urandom_range(0, 2) == 0) pal[$urandom_range(0, 3) * COLW +: COLW] = 8'hFF;
                    send_beat(make_draw(px, py, TILE_NUMW'(t), pal,
                                        1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1))));
                end
            end
        end

        settle();
        if (sb.mismatches == 0) begin
            $display("tile_sprite_blitter_top_tb: PASS");
        end else begin
            $display("tile_sprite_blitter_top_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== tile_sprite_blitter_top.f =====
src/tsb_pkg.sv
src/tsb_pix_unit.sv
src/tile_sprite_blitter_top.sv
tb/sv/blit_check_pkg.sv
tb/sv/tile_sprite_blitter_top_tb.sv
